[rtl/core/kp_pkg.sv]
// kp_pkg: shared constants and types for the 0-1 knapsack solver
// depends on nothing; used by kp_mem, kp_ctrl and knapsack_01_max_value_top
package kp_pkg;

  // table geometry
  localparam int unsigned MaxCap = 1023;
  localparam int unsigned Depth  = MaxCap + 1;
  localparam int unsigned AddrW  = $clog2(Depth);

  // field widths
  localparam int unsigned WeightW = 10;
  localparam int unsigned ValueW  = 16;
  localparam int unsigned BestW   = 32;
  localparam int unsigned CapW    = 10;

  localparam logic [CapW-1:0] CapReset = CapW'(1023);

  typedef logic [AddrW-1:0] addr_t;
  typedef logic [BestW-1:0] best_t;

  // memory request from the sequencer
  typedef struct packed {
    logic  rd_en;
    addr_t rd_addr_a;
    addr_t rd_addr_b;
    logic  wr_en;
    addr_t wr_addr;
    best_t wr_data;
  } mem_req_t;

endpackage

[rtl/core/kp_mem.sv]
// kp_mem: best-value table, one write port and two registered read ports
// depends on kp_pkg
module kp_mem (
  input  logic             clk_i,
  input  kp_pkg::mem_req_t req_i,
  output kp_pkg::best_t    rd_data_a_o,
  output kp_pkg::best_t    rd_data_b_o
);
  import kp_pkg::*;

  best_t mem_q [Depth];
  best_t rd_a_q;
  best_t rd_b_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem_q[req_i.wr_addr] <= req_i.wr_data;
    end
  end

  // read ports, registered, hold when not enabled
  always_ff @(posedge clk_i) begin
    if (req_i.rd_en) begin
      rd_a_q <= mem_q[req_i.rd_addr_a];
      rd_b_q <= mem_q[req_i.rd_addr_b];
    end
  end

  assign rd_data_a_o = rd_a_q;
  assign rd_data_b_o = rd_b_q;

endmodule

[rtl/core/kp_ctrl.sv]
// kp_ctrl: sweep sequencer, update datapath, result and clearing pass
// depends on kp_pkg; drives the table in kp_mem
module kp_ctrl (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  input  logic [kp_pkg::WeightW-1:0]  item_weight_i,
  input  logic [kp_pkg::ValueW-1:0]   item_value_i,
  input  logic                        last_item_i,
  input  logic                        cfg_we_i,
  input  logic [kp_pkg::CapW-1:0]     cfg_wdata_i,
  input  kp_pkg::best_t               rd_data_a_i,
  input  kp_pkg::best_t               rd_data_b_i,
  output kp_pkg::mem_req_t            req_o,
  output logic                        busy,
  output logic                        strobe
);
  import kp_pkg::*;

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StSweep = 3'd1;
  localparam logic [2:0] StDrain = 3'd2;
  localparam logic [2:0] StRead  = 3'd3;
  localparam logic [2:0] StOut   = 3'd4;
  localparam logic [2:0] StClear = 3'd5;

  logic [2:0]         state_q, state_d;
  addr_t              cnt_q, cnt_d;
  logic [WeightW-1:0] w_q;
  logic [ValueW-1:0]  v_q;
  logic               last_q;
  logic [CapW-1:0]    cap_q;
  logic               s1_valid_q, s1_valid_d;
  addr_t              s1_addr_q, s1_addr_d;

  logic               accept;
  logic               too_heavy;
  addr_t              cap_eff;
  logic [BestW:0]     sum;
  best_t              cand;
  best_t              upd;

  assign accept    = start && (state_q == StIdle);
  assign too_heavy = 32'(w_q) > MaxCap;
  assign cap_eff   = (32'(cap_q) > MaxCap) ? AddrW'(MaxCap) : AddrW'(cap_q);

  // candidate value, saturating at all ones
  assign sum  = {1'b0, rd_data_b_i} + (BestW + 1)'(v_q);
  assign cand = sum[BestW] ? '1 : sum[BestW-1:0];
  assign upd  = (cand > rd_data_a_i) ? cand : rd_data_a_i;

  // capacity register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CapReset;
    end else if (cfg_we_i) begin
      cap_q <= cfg_wdata_i;
    end
  end

  // item latch
  always_ff @(posedge clk_i) begin
    if (accept) begin
      w_q    <= item_weight_i;
      v_q    <= item_value_i;
      last_q <= last_item_i;
    end
  end

  // sequencer and read stage
  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    s1_valid_d = 1'b0;
    s1_addr_d  = s1_addr_q;
    req_o      = '0;
    case (state_q)
      StIdle: begin
        if (accept) begin
          state_d = StSweep;
          cnt_d   = AddrW'(MaxCap);
        end
      end
      StSweep: begin
        if (too_heavy) begin
          state_d = StDrain;
        end else begin
          req_o.rd_en     = 1'b1;
          req_o.rd_addr_a = cnt_q;
          req_o.rd_addr_b = AddrW'(cnt_q - AddrW'(w_q));
          s1_valid_d      = 1'b1;
          s1_addr_d       = cnt_q;
          if (cnt_q == AddrW'(w_q)) begin
            state_d = StDrain;
          end else begin
            cnt_d = cnt_q - AddrW'(1);
          end
        end
      end
      StDrain: begin
        state_d = last_q ? StRead : StIdle;
      end
      StRead: begin
        req_o.rd_en     = 1'b1;
        req_o.rd_addr_a = cap_eff;
        req_o.rd_addr_b = cap_eff;
        state_d         = StOut;
      end
      StOut: begin
        state_d = StClear;
        cnt_d   = AddrW'(MaxCap);
      end
      StClear: begin
        req_o.wr_en   = 1'b1;
        req_o.wr_addr = cnt_q;
        req_o.wr_data = '0;
        if (cnt_q == '0) begin
          state_d = StIdle;
        end else begin
          cnt_d = cnt_q - AddrW'(1);
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
    // write-back stage of the sweep
    if (s1_valid_q) begin
      req_o.wr_en   = 1'b1;
      req_o.wr_addr = s1_addr_q;
      req_o.wr_data = upd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StClear;
      cnt_q      <= AddrW'(MaxCap);
      s1_valid_q <= 1'b0;
      s1_addr_q  <= '0;
    end else begin
      state_q    <= state_d;
      cnt_q      <= cnt_d;
      s1_valid_q <= s1_valid_d;
      s1_addr_q  <= s1_addr_d;
    end
  end

  assign busy   = (state_q != StIdle);
  assign strobe = (state_q == StOut);

endmodule

[rtl/core/knapsack_01_max_value_top.sv]
// knapsack_01_max_value_top: 0-1 knapsack solver top level
// depends on kp_pkg, kp_ctrl and kp_mem
//
// Items are taken when start is high and busy is low. Each item sweeps the
// best-value table from entry 1023 down to its weight, one entry per cycle
// through a two-read, one-write table memory with registered read ports.
// A drain state then writes back the last entry. For the item marked last,
// the result is on the ports in the output state that follows the drain and
// read states, with strobe high for exactly one cycle; the receiver cannot
// stall it and must take it then. The table is then cleared one entry per
// cycle, all 1024 entries, before busy drops. The same clearing pass runs
// right after reset. Capacity may be written at any time and does not clear
// the table.
module knapsack_01_max_value_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic [kp_pkg::WeightW-1:0]  item_weight_i,
  input  logic [kp_pkg::ValueW-1:0]   item_value_i,
  input  logic                        last_item_i,
  output logic                        strobe,
  output logic [kp_pkg::BestW-1:0]    best_value_o,
  input  logic                        cfg_we_i,
  input  logic [kp_pkg::CapW-1:0]     cfg_wdata_i
);
  import kp_pkg::*;

  mem_req_t req;
  best_t    rd_a;
  best_t    rd_b;

  // sequencer and datapath
  kp_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .item_weight_i (item_weight_i),
    .item_value_i  (item_value_i),
    .last_item_i   (last_item_i),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .rd_data_a_i   (rd_a),
    .rd_data_b_i   (rd_b),
    .req_o         (req),
    .busy          (busy),
    .strobe        (strobe)
  );

  // best-value table
  kp_mem u_mem (
    .clk_i       (clk_i),
    .req_i       (req),
    .rd_data_a_o (rd_a),
    .rd_data_b_o (rd_b)
  );

  // result comes straight from the registered read port
  assign best_value_o = rd_a;

endmodule

[rtl/core/kp_chk.sv]
// kp_chk: port-level checks for knapsack_01_max_value_top
// depends on nothing; bound to the top level below
module kp_chk (
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input logic strobe
);

  // a result is shown only while the block is busy
  a_strobe_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe |-> busy)
    else $error("strobe while not busy");

  // the clearing pass follows each result
  a_clear_after: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe |=> busy && !strobe)
    else $error("no clearing pass after result");

  // an accepted item makes the block busy
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("item accepted but block not busy");

  // no result straight out of idle
  a_no_idle_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy |=> !strobe)
    else $error("result without a sweep");

endmodule

bind knapsack_01_max_value_top kp_chk u_kp_chk (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .start  (start),
  .busy   (busy),
  .strobe (strobe)
);

[tb/sv/knapsack_01_max_value_top_tb.sv]
// testbench for knapsack_01_max_value_top: directed sets, then random sets
// with random gaps and capacity changes, checked against a best-value predictor
// depends on kp_pkg and the knapsack_01_max_value_top rtl

// best-value predictor and store of expected set results
class kp_best_tracker;
  kp_pkg::best_t              best_by_cap [kp_pkg::Depth];
  logic [kp_pkg::CapW-1:0]    capacity;
  kp_pkg::best_t              pending_best [$];
  int unsigned                errors;

  function new();
    clear_table();
    capacity = kp_pkg::CapReset;
    errors   = 0;
  endfunction

  function void clear_table();
    foreach (best_by_cap[i]) best_by_cap[i] = '0;
  endfunction

  // fold one accepted item into the table, high capacity first
  function void fold_item(input logic [kp_pkg::WeightW-1:0] w,
                          input logic [kp_pkg::ValueW-1:0]  v,
                          input logic                       last);
    logic [kp_pkg::BestW:0] sum;
    kp_pkg::best_t          cand;
    int                     wi;
    wi = int'(w);
    for (int c = kp_pkg::MaxCap; c >= wi; c--) begin
      sum  = {1'b0, best_by_cap[c - wi]} + v;
      cand = sum[kp_pkg::BestW] ? '1 : sum[kp_pkg::BestW-1:0];
      if (cand > best_by_cap[c]) best_by_cap[c] = cand;
    end
    // last item of the set: report the configured capacity, then start over
    if (last) begin
      pending_best.push_back(best_by_cap[capacity]);
      clear_table();
    end
  endfunction

  // compare one strobed result with the oldest expected value
  function void check_best(input kp_pkg::best_t got);
    kp_pkg::best_t want;
    if (pending_best.size() == 0) begin
      errors++;
      if (errors <= 10) $display("unexpected result: best_value %0d", got);
      return;
    end
    want = pending_best.pop_front();
    if (got !== want) begin
      errors++;
      if (errors <= 10)
        $display("best_value mismatch: expected %0d, got %0d", want, got);
    end
  endfunction
endclass

module knapsack_01_max_value_top_tb;
  import kp_pkg::*;

  localparam int unsigned QuietLimit  = 20000;
  localparam int unsigned DrainCycles = 2100;
  localparam int unsigned ItemTarget  = 550;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                start         = 1'b0;
  logic [WeightW-1:0]  item_weight_i = '0;
  logic [ValueW-1:0]   item_value_i  = '0;
  logic                last_item_i   = 1'b0;
  logic                cfg_we_i      = 1'b0;
  logic [CapW-1:0]     cfg_wdata_i   = '0;
  logic                busy;
  logic                strobe;
  logic [BestW-1:0]    best_value_o;

  kp_best_tracker      tracker = new();
  int unsigned         items_sent = 0;
  int unsigned         quiet_cycles = 0;

  knapsack_01_max_value_top uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .item_weight_i (item_weight_i),
    .item_value_i  (item_value_i),
    .last_item_i   (last_item_i),
    .strobe        (strobe),
    .best_value_o  (best_value_o),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  // clock
  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // result monitor
  always @(posedge clk_i) begin
    if (rst_ni && strobe) tracker.check_best(best_value_o);
  end

  // watchdog on cycles with no item and no result moving
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || strobe) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QuietLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // offer one item, optionally after the block goes idle and a gap
  task automatic send_item(input logic [WeightW-1:0] w, input logic [ValueW-1:0] v,
                           input logic last, input int unsigned gap,
                           input bit after_idle);
    @(negedge clk_i);
    if (gap != 0 || after_idle) begin
      start = 1'b0;
      if (after_idle) begin
        do @(posedge clk_i); while (busy);
        @(negedge clk_i);
      end
      repeat (gap) @(negedge clk_i);
    end
    start         = 1'b1;
    item_weight_i = w;
    item_value_i  = v;
    last_item_i   = last;
    do @(posedge clk_i); while (busy);
    tracker.fold_item(w, v, last);
    items_sent++;
  endtask

  // write capacity once the block is idle and no result is outstanding
  task automatic write_capacity(input logic [CapW-1:0] cap);
    @(negedge clk_i);
    start = 1'b0;
    do @(posedge clk_i); while (busy || tracker.pending_best.size() != 0);
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_wdata_i = cap;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    tracker.capacity = cap;
  endtask

  function automatic logic [CapW-1:0] pick_capacity();
    case ($urandom_range(0, 4))
      0:       return '0;
      1:       return CapW'(MaxCap);
      2:       return CapW'($urandom_range(1, 100));
      default: return CapW'($urandom);
    endcase
  endfunction

  // stimulus
  initial begin
    int unsigned        set_len;
    bit                 no_gaps;
    logic [WeightW-1:0] w;
    logic [ValueW-1:0]  v;

    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;

    // reset capacity: zero weight adds to every entry, full weight on top
    send_item(10'd0, 16'hFFFF, 1'b0, 0, 1'b0);
    send_item(10'd1023, 16'hFFFF, 1'b1, 0, 1'b0);

    // capacity zero: too heavy gives an empty answer, zero weight still counts
    write_capacity('0);
    send_item(10'd1, 16'd5, 1'b1, 0, 1'b0);
    send_item(10'd0, 16'd7, 1'b0, 3, 1'b0);
    send_item(10'd0, 16'd0, 1'b1, 0, 1'b1);

    // textbook set
    write_capacity(CapW'(50));
    send_item(10'd10, 16'd60, 1'b0, 0, 1'b0);
    send_item(10'd20, 16'd100, 1'b0, 5, 1'b0);
    send_item(10'd30, 16'd120, 1'b1, 0, 1'b1);

    // large capacity, weights that just overflow it together
    write_capacity(CapW'(MaxCap));
    send_item(10'd512, 16'd1000, 1'b0, 0, 1'b0);
    send_item(10'd511, 16'd2000, 1'b0, 0, 1'b0);
    send_item(10'd1, 16'd3000, 1'b1, 11, 1'b0);

    // capacity changed in the middle of a set
    send_item(10'd5, 16'd10, 1'b0, 0, 1'b0);
    send_item(10'd6, 16'd20, 1'b0, 0, 1'b0);
    write_capacity(CapW'(5));
    send_item(10'd3, 16'd1, 1'b1, 0, 1'b0);

    // alternating bit patterns and a zero value at full weight
    write_capacity(CapW'(10'h2AA));
    send_item(10'd1023, 16'd0, 1'b0, 0, 1'b0);
    send_item(10'h155, 16'h5555, 1'b0, 0, 1'b0);
    send_item(10'h2AA, 16'hAAAA, 1'b1, 0, 1'b0);
    write_capacity(CapW'(10'h155));
    send_item(10'h155, 16'h5555, 1'b0, 0, 1'b0);
    send_item(10'h2AA, 16'hAAAA, 1'b1, 0, 1'b0);

    // random sets
    while (items_sent < ItemTarget) begin
      set_len = $urandom_range(1, 8);
      no_gaps = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 2) == 0) write_capacity(pick_capacity());
      for (int i = 0; i < set_len; i++) begin
        if (i != 0 && $urandom_range(0, 19) == 0) write_capacity(pick_capacity());
        case ($urandom_range(0, 3))
          0:       w = WeightW'($urandom_range(0, 63));
          1:       w = WeightW'($urandom_range(900, 1023));
          default: w = WeightW'($urandom);
        endcase
        case ($urandom_range(0, 7))
          0:       v = '0;
          1:       v = '1;
          default: v = ValueW'($urandom);
        endcase
        send_item(w, v, logic'(i == set_len - 1),
                  no_gaps ? 0 : $urandom_range(0, 11),
                  no_gaps ? 1'b0 : bit'($urandom_range(0, 1)));
      end
    end

    // drain
    @(negedge clk_i);
    start = 1'b0;
    do @(posedge clk_i); while (tracker.pending_best.size() != 0);
    repeat (DrainCycles) @(posedge clk_i);

    if (tracker.errors == 0 && tracker.pending_best.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
